// File: src/mac_parse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mac_parse_pkg
// Shared constants and character decoding for the MAC address text parser.
// ----------------------------------------------------------------------------
package mac_parse_pkg;

	localparam int unsigned CharWidth    = 8;
	localparam int unsigned NumBytes     = 6;
	localparam int unsigned AddrWidth    = 8 * NumBytes;
	localparam int unsigned BytePosWidth = 3;
	localparam int unsigned DigitWidth   = 4;
	localparam int unsigned CountWidth   = 5;

	localparam logic [DigitWidth-1:0]   DigitsNeeded = 4'd12;
	localparam logic [CountWidth-1:0]   LenPlain     = 5'd12;
	localparam logic [CountWidth-1:0]   LenSeparated = 5'd17;
	localparam logic [CountWidth-1:0]   CountMax     = 5'd31;
	localparam logic [BytePosWidth-1:0] BytePosLimit = 3'd6;

	localparam logic [CharWidth-1:0] ChDot    = 8'h2E;
	localparam logic [CharWidth-1:0] ChColon  = 8'h3A;
	localparam logic [CharWidth-1:0] ChDash   = 8'h2D;
	localparam logic [CharWidth-1:0] ChZero   = 8'h30;
	localparam logic [CharWidth-1:0] ChNine   = 8'h39;
	localparam logic [CharWidth-1:0] ChLowA   = 8'h61;
	localparam logic [CharWidth-1:0] ChLowF   = 8'h66;
	localparam logic [CharWidth-1:0] ChUpA    = 8'h41;
	localparam logic [CharWidth-1:0] ChUpF    = 8'h46;
	localparam logic [DigitWidth-1:0] TenVal  = 4'd10;

	typedef struct packed {
		logic                  is_hex;
		logic [DigitWidth-1:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [CharWidth-1:0] c);
		hex_digit_t r;
		logic [CharWidth-1:0] diff;
		r = '0;
		diff = '0;
		if (c >= ChZero && c <= ChNine) begin
			diff = c - ChZero;
			r.is_hex = 1'b1;
			r.value = diff[DigitWidth-1:0];
		end else if (c >= ChLowA && c <= ChLowF) begin
			diff = c - ChLowA;
			r.is_hex = 1'b1;
			r.value = diff[DigitWidth-1:0] + TenVal;
		end else if (c >= ChUpA && c <= ChUpF) begin
			diff = c - ChUpA;
			r.is_hex = 1'b1;
			r.value = diff[DigitWidth-1:0] + TenVal;
		end
		return r;
	endfunction

	function automatic logic is_separator(input logic [CharWidth-1:0] c);
		return (c == ChDot) || (c == ChColon) || (c == ChDash);
	endfunction

endpackage
`default_nettype wire

// File: src/mac_address_text_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mac_address_text_parser_top
// Parses MAC address text, one character per transfer, into six bytes.
// A result loads into the output register (m_tvalid) once its last character
// has landed in the input register and the output register is free to take it.
// Throughput: one character per cycle; only a last character waits on a full
// result register.
// Reset: arst_n clears parse state and valid flags; the state also returns
// to reset after every last character.
// ----------------------------------------------------------------------------
module mac_address_text_parser_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output      logic s_tready,
	input  wire logic [mac_parse_pkg::CharWidth-1:0] s_tdata,  // [7:0] char_in
	input  wire logic s_tlast,                                 // is_last
	output      logic m_tvalid,
	input  wire logic m_tready,
	output      logic [mac_parse_pkg::AddrWidth-1:0] m_tdata,  // [47:0] mac_addr
	output      logic m_tuser                                  // [0] ok
);
	import mac_parse_pkg::*;

	logic                    valid_s1;
	logic [CharWidth-1:0]    char_s1;
	logic                    last_s1;

	logic [AddrWidth-1:0]    addr_q;
	logic [BytePosWidth-1:0] byte_pos_q;
	logic                    run_q;
	logic [DigitWidth-1:0]   total_q;
	logic                    halted_q;
	logic [CountWidth-1:0]   count_q;

	logic [AddrWidth-1:0]    addr_nx;
	logic [BytePosWidth-1:0] byte_pos_nx;
	logic                    run_nx;
	logic [DigitWidth-1:0]   total_nx;
	logic                    halted_nx;
	logic [CountWidth-1:0]   count_nx;

	logic                    out_valid_q;
	logic [AddrWidth-1:0]    out_addr_q;
	logic                    out_ok_q;

	hex_digit_t              hd;
	logic                    out_free;
	logic                    advance;
	logic                    len_ok;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_addr_q;
	assign m_tuser  = out_ok_q;

	assign hd = hex_decode(char_s1);

	always_comb begin
		addr_nx     = addr_q;
		byte_pos_nx = byte_pos_q;
		run_nx      = run_q;
		total_nx    = total_q;
		halted_nx   = halted_q;
		count_nx    = (count_q != CountMax) ? count_q + 1'b1 : count_q;
		if (!halted_q) begin
			if (hd.is_hex) begin
				for (int i = 0; i < NumBytes; i++) begin
					if (byte_pos_q == BytePosWidth'(i) && byte_pos_q < BytePosLimit) begin
						addr_nx[8*(NumBytes-1-i) +: 8] =
							{addr_q[8*(NumBytes-1-i) +: 4], hd.value};
					end
				end
				total_nx = total_q + 1'b1;
				run_nx   = !run_q;
				if (run_q) begin
					byte_pos_nx = byte_pos_q + 1'b1;
				end
				if (total_nx >= DigitsNeeded) begin
					halted_nx = 1'b1;
				end
			end else if (is_separator(char_s1)) begin
				run_nx = 1'b0;
			end else begin
				halted_nx = 1'b1;
			end
		end
		len_ok = (count_nx == LenPlain) || (count_nx == LenSeparated);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			addr_q      <= '0;
			byte_pos_q  <= '0;
			run_q       <= 1'b0;
			total_q     <= '0;
			halted_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (last_s1) begin
					addr_q      <= '0;
					byte_pos_q  <= '0;
					run_q       <= 1'b0;
					total_q     <= '0;
					halted_q    <= 1'b0;
					count_q     <= '0;
				end else begin
					addr_q      <= addr_nx;
					byte_pos_q  <= byte_pos_nx;
					run_q       <= run_nx;
					total_q     <= total_nx;
					halted_q    <= halted_nx;
					count_q     <= count_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance && last_s1) begin
			out_addr_q <= len_ok ? addr_nx : '0;
			out_ok_q   <= len_ok && (total_nx == DigitsNeeded) && !halted_q;
		end
	end

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for mac_address_text_parser_top. Address texts (well-formed
// ones with random separators and letter case, broken and overlong ones, and
// raw byte noise) are fed one character per transfer. A scoreboard tracks the
// parse state of each text, predicts the six bytes and the ok flag on the last
// character, and checks every result transfer in order. Both sides stall at
// random in the first two of three phases and not at all in the third.
// ----------------------------------------------------------------------------
module tb_top;
	import mac_parse_pkg::*;

	localparam int StallLimit = 2000;

	typedef struct {
		logic [AddrWidth-1:0] mac;
		logic                 ok;
	} mac_result_t;

	class mac_text_scoreboard;
		logic [AddrWidth-1:0]    addr_acc;
		logic [BytePosWidth-1:0] byte_idx;
		logic [1:0]              run_len;
		logic [DigitWidth-1:0]   digit_total;
		bit                      stopped;
		logic [CountWidth-1:0]   text_len;
		mac_result_t             parsed_q[$];
		int                      errors;

		function new();
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			addr_acc    = '0;
			byte_idx    = '0;
			run_len     = '0;
			digit_total = '0;
			stopped     = 1'b0;
			text_len    = '0;
		endfunction

		static function bit hex_digit(input logic [CharWidth-1:0] c,
			output logic [DigitWidth-1:0] v);
			v = c[3:0];
			if (c inside {[ChZero:ChNine]})
				return 1'b1;
			if (c inside {[ChLowA:ChLowF], [ChUpA:ChUpF]}) begin
				v = c[3:0] + 4'd9;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		static function bit is_sep(input logic [CharWidth-1:0] c);
			return c == ChDot || c == ChColon || c == ChDash;
		endfunction

		function int pending();
			return parsed_q.size();
		endfunction

		task report(input string what);
			$display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		function void take_char(input logic [CharWidth-1:0] c, input logic is_last);
			logic [DigitWidth-1:0] v;
			bit          late;
			bit          len_ok;
			int          sh;
			mac_result_t r;
			late = stopped;
			if (text_len != CountMax)
				text_len++;
			if (!stopped) begin
				if (hex_digit(c, v)) begin
					if (byte_idx < NumBytes) begin
						sh = 40 - 8 * int'(byte_idx);
						addr_acc[sh +: 8] = {addr_acc[sh +: 4], v};
					end
					run_len++;
					digit_total++;
					if (run_len == 2'd2) begin
						run_len = '0;
						byte_idx++;
					end
					if (digit_total == DigitsNeeded)
						stopped = 1'b1;
				end else if (is_sep(c)) begin
					run_len = '0;
				end else begin
					stopped = 1'b1;
				end
			end
			if (is_last) begin
				len_ok = text_len == LenPlain || text_len == LenSeparated;
				r.mac  = len_ok ? addr_acc : '0;
				r.ok   = len_ok && digit_total == DigitsNeeded && !late;
				parsed_q.push_back(r);
				clear_text();
			end
		endfunction

		task check_result(input logic [AddrWidth-1:0] mac, input logic ok);
			mac_result_t r;
			if (parsed_q.size() == 0) begin
				report($sformatf("unexpected result mac=%h ok=%b", mac, ok));
			end else begin
				r = parsed_q.pop_front();
				if (mac !== r.mac)
					report($sformatf("mac %h, expected %h", mac, r.mac));
				if (ok !== r.ok)
					report($sformatf("ok %b, expected %b (mac %h)", ok, r.ok, r.mac));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [CharWidth-1:0] s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [AddrWidth-1:0] m_tdata;
	logic                 m_tuser;

	mac_text_scoreboard   sb = new();
	logic [CharWidth-1:0] text_q[$];
	int                   src_idle = 24;
	int                   sink_idle = 72;
	int                   idle_cycles = 0;
	int                   chars_sent;
	int                   texts_sent;

	mac_address_text_parser_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= $urandom_range(99) >= sink_idle;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.take_char(s_tdata, s_tlast);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [CharWidth-1:0] rand_byte();
		return CharWidth'($urandom_range(255));
	endfunction

	function automatic logic [CharWidth-1:0] rand_hex();
		int unsigned n;
		n = $urandom_range(15);
		if (n < 10)
			return ChZero + CharWidth'(n);
		return ($urandom_range(1) ? ChUpA : ChLowA) + CharWidth'(n - 10);
	endfunction

	function automatic logic [CharWidth-1:0] rand_sep();
		case ($urandom_range(2))
			0: return ChDot;
			1: return ChColon;
			default: return ChDash;
		endcase
	endfunction

	function automatic logic [CharWidth-1:0] rand_stop();
		logic [CharWidth-1:0]  c;
		logic [DigitWidth-1:0] v;
		do
			c = rand_byte();
		while (mac_text_scoreboard::hex_digit(c, v) || mac_text_scoreboard::is_sep(c));
		return c;
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic void push_address(input bit separated);
		logic [CharWidth-1:0] sep;
		sep = rand_sep();
		for (int b = 0; b < NumBytes; b++) begin
			if (separated && b > 0)
				text_q.push_back($urandom_range(3) == 0 ? rand_sep() : sep);
			text_q.push_back(rand_hex());
			text_q.push_back(rand_hex());
		end
	endfunction

	function automatic void build_text();
		int target;
		text_q.delete();
		case ($urandom_range(11))
			0, 1, 2: push_address(1'b1);
			3, 4: push_address(1'b0);
			5: begin
				push_address(1'b1);
				text_q[$urandom_range(text_q.size() - 1)] = rand_byte();
			end
			6: begin
				push_address($urandom_range(1) != 0);
				if ($urandom_range(1))
					text_q.push_back(rand_byte());
				else
					text_q.delete($urandom_range(text_q.size() - 1));
			end
			7: begin
				target = $urandom_range(1, 40);
				repeat (target) text_q.push_back(rand_byte());
			end
			8: begin
				target = $urandom_range(1) ? int'(LenSeparated) : int'(LenPlain);
				while (text_q.size() < target) begin
					if (text_q.size() > 0 && $urandom_range(2) == 0)
						text_q.push_back(rand_sep());
					else
						text_q.push_back(rand_hex());
				end
			end
			9: begin
				push_address(1'b0);
				text_q[$urandom_range(text_q.size() - 1)] = rand_stop();
			end
			10: begin
				target = $urandom_range(25, 40);
				repeat (target) text_q.push_back($urandom_range(3) == 0 ? rand_sep() : rand_hex());
			end
			default: begin
				repeat (LenSeparated) text_q.push_back(rand_hex());
			end
		endcase
	endfunction

	task automatic send_char(input logic [CharWidth-1:0] c, input logic is_last);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= is_last;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		chars_sent += text_q.size();
		texts_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		text_q.delete();
		push_str("0123456789aF");
		send_text();
		text_q.delete();
		push_str("Zx");
		send_text();
		text_q = {8'h00};
		send_text();
		text_q = {8'hFF};
		send_text();
		text_q.delete();
		push_str("a-B.c:");
		text_q.push_back(8'hFF);
		send_text();

		for (int phase = 0; phase < 3; phase++) begin
			src_idle  = phase == 0 ? 24 : phase == 1 ? 72 : 0;
			sink_idle = phase == 0 ? 72 : phase == 1 ? 24 : 0;
			if (phase > 0)
				drain();
			chars_sent = 0;
			texts_sent = 0;
			while (chars_sent < 140 || texts_sent < 8) begin
				build_text();
				send_text();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: mac_address_text_parser_top.f
src/mac_parse_pkg.sv
src/mac_address_text_parser_top.sv
bench/tb_top.sv
